// ===== rtl/ilist_pkg.sv =====
// Shared types and codes for the indexed list block.
package ilist_pkg;

	// Operation codes carried by the operation field.
	localparam logic [2:0] OP_APPEND   = 3'd0;
	localparam logic [2:0] OP_INSERT   = 3'd1;
	localparam logic [2:0] OP_REM_LAST = 3'd2;
	localparam logic [2:0] OP_REM_AT   = 3'd3;
	localparam logic [2:0] OP_SEARCH   = 3'd4;

	// Status codes returned with each result.
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_OOB      = 3'd1;
	localparam logic [2:0] ST_EMPTY    = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;

	// Result fields as the sequencer hands them to the output register.
	typedef struct packed {
		logic [2:0] status;
		logic [7:0] found_index;
		logic [8:0] entry_count;
	} res_t;

endpackage

// ===== rtl/indexed_list_insert_remove_search.sv =====
// Top level of the indexed list: request port, sequencer, store and result register.
// A packed ordered list of 32-bit values in a store of DEPTH entries. Each request
// item carries one operation (append, insert at, remove last, remove at, search) and
// yields exactly one result item with a status, the found index and the entry count.
// One item is worked on at a time. Append, remove-last, insert at the tail, removal of
// the tail entry, undefined codes, a search of an empty list and every error case go
// straight to the result. Insert at a position below the count first shifts the entries
// from the tail down to that position up by one, remove at a position below the last
// entry shifts the entries after it down by one, and a search reads the entries from
// index 0 until a hit or the end of the list. The next item is accepted only after the
// result has moved into the output register. The walks are paced by the single read
// port of the entry store, which moves or compares one entry a cycle. The store needs
// no clearing after reset; it is ready at once.
module indexed_list_insert_remove_search #(
	parameter int DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [2:0]  operation,
	input  logic [7:0]  position,
	input  logic [31:0] item_value,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [2:0]  status,
	output logic [7:0]  found_index,
	output logic [8:0]  entry_count
);

	localparam int AW = $clog2(DEPTH);

	logic            idle;
	logic            start;
	logic            res_valid;
	logic            res_take;
	ilist_pkg::res_t res;
	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	logic [31:0]     mem_wdata;
	logic [AW-1:0]   mem_raddr;
	logic [31:0]     mem_rdata;
	logic            rsp_valid_q;
	ilist_pkg::res_t rsp_q;

	// A request item is taken only while the sequencer is idle.
	assign req_stall = !idle;
	assign start     = req_valid && idle;

	// The result register frees when empty or when its item is taken.
	assign res_take  = !rsp_valid_q || !rsp_stall;

	ilist_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.op        (operation),
		.pos       (position),
		.val       (item_value),
		.idle      (idle),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	ilist_mem #(
		.DEPTH(DEPTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Output register holding one result item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else if (res_take) begin
			rsp_valid_q <= res_valid;
			if (res_valid) begin
				rsp_q <= res;
			end
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = rsp_q.status;
	assign found_index = rsp_q.found_index;
	assign entry_count = rsp_q.entry_count;

endmodule

// ===== rtl/ilist_mem.sv =====
// Entry store: one write port and one read port with registered read data.
module ilist_mem #(
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [31:0]              wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [31:0]              rdata
);

	logic [31:0] mem [DEPTH];

	// Write when enabled, and registered read every cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/ilist_ctrl.sv =====
// Sequencer that walks the entry store for shifts and searches.
module ilist_ctrl #(
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [2:0]               op,
	input  logic [7:0]               pos,
	input  logic [31:0]              val,
	output logic                     idle,
	output logic                     res_valid,
	input  logic                     res_take,
	output ilist_pkg::res_t          res,
	output logic                     mem_we,
	output logic [$clog2(DEPTH)-1:0] mem_waddr,
	output logic [31:0]              mem_wdata,
	output logic [$clog2(DEPTH)-1:0] mem_raddr,
	input  logic [31:0]              mem_rdata
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_SHIFT_UP = 3'd1;
	localparam logic [2:0] S_SHIFT_DN = 3'd2;
	localparam logic [2:0] S_SEARCH   = 3'd3;
	localparam logic [2:0] S_FINAL    = 3'd4;
	localparam logic [2:0] S_DONE     = 3'd5;

	logic [2:0]    state_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] rptr_q;
	logic [AW-1:0] wa_q;
	logic [AW-1:0] pos_q;
	logic [AW-1:0] idx_q;
	logic [31:0]   val_q;
	logic [2:0]    status_q;
	logic          pend_q;
	logic          rd_left_q;
	logic          ins_q;

	logic [31:0]   pos_w;
	logic [31:0]   cnt_w;
	logic          full;
	logic          last_rd;
	logic          hit;

	assign pos_w   = {24'd0, pos};
	assign cnt_w   = 32'(count_q);
	assign full    = (count_q == CW'(DEPTH));
	// The read pointer has reached the last valid entry.
	assign last_rd = (CW'(rptr_q) == count_q - CW'(1));
	// The compare unit: data read last cycle against the key.
	assign hit     = pend_q && (mem_rdata == val_q);

	assign idle      = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res.status      = status_q;
	assign res.found_index = 8'(idx_q);
	assign res.entry_count = 9'(count_q);
	assign mem_raddr = rptr_q;

	// Store writes: direct append or insert at the tail, shift moves, final insert.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = wa_q;
		mem_wdata = mem_rdata;
		case (state_q)
			S_IDLE: begin
				if (start && op == ilist_pkg::OP_APPEND && !full) begin
					mem_we    = 1'b1;
					mem_waddr = AW'(count_q);
					mem_wdata = val;
				end else if (start && op == ilist_pkg::OP_INSERT && !full
						&& pos_w == cnt_w) begin
					mem_we    = 1'b1;
					mem_waddr = AW'(pos);
					mem_wdata = val;
				end
			end
			S_SHIFT_UP, S_SHIFT_DN: begin
				mem_we = pend_q;
			end
			S_FINAL: begin
				if (ins_q) begin
					mem_we    = 1'b1;
					mem_waddr = pos_q;
					mem_wdata = val_q;
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Sequencer: one store read per cycle, the write or compare acting on the registered read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			rptr_q    <= '0;
			wa_q      <= '0;
			pos_q     <= '0;
			idx_q     <= '0;
			val_q     <= '0;
			status_q  <= ilist_pkg::ST_OK;
			pend_q    <= 1'b0;
			rd_left_q <= 1'b0;
			ins_q     <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						pend_q    <= 1'b0;
						rd_left_q <= 1'b1;
						idx_q     <= '0;
						status_q  <= ilist_pkg::ST_OK;
						val_q     <= val;
						state_q   <= S_DONE;
						case (op)
							ilist_pkg::OP_APPEND: begin
								if (full) begin
									status_q <= ilist_pkg::ST_FULL;
								end else begin
									count_q <= count_q + CW'(1);
								end
							end
							ilist_pkg::OP_INSERT: begin
								if (pos_w > cnt_w) begin
									status_q <= ilist_pkg::ST_OOB;
								end else if (full) begin
									status_q <= ilist_pkg::ST_FULL;
								end else if (pos_w == cnt_w) begin
									count_q <= count_q + CW'(1);
								end else begin
									rptr_q  <= AW'(count_q - CW'(1));
									pos_q   <= AW'(pos);
									ins_q   <= 1'b1;
									state_q <= S_SHIFT_UP;
								end
							end
							ilist_pkg::OP_REM_LAST: begin
								if (count_q == '0) begin
									status_q <= ilist_pkg::ST_EMPTY;
								end else begin
									count_q <= count_q - CW'(1);
								end
							end
							ilist_pkg::OP_REM_AT: begin
								if (pos_w >= cnt_w) begin
									status_q <= ilist_pkg::ST_OOB;
								end else if (pos_w + 32'd1 == cnt_w) begin
									count_q <= count_q - CW'(1);
								end else begin
									rptr_q  <= AW'(pos) + AW'(1);
									ins_q   <= 1'b0;
									state_q <= S_SHIFT_DN;
								end
							end
							ilist_pkg::OP_SEARCH: begin
								if (count_q == '0) begin
									status_q <= ilist_pkg::ST_NOTFOUND;
								end else begin
									rptr_q  <= '0;
									state_q <= S_SEARCH;
								end
							end
							default: begin
								status_q <= ilist_pkg::ST_OK;
							end
						endcase
					end
				end
				S_SHIFT_UP: begin
					pend_q <= rd_left_q;
					if (rd_left_q) begin
						wa_q <= rptr_q + AW'(1);
						if (rptr_q == pos_q) begin
							rd_left_q <= 1'b0;
						end else begin
							rptr_q <= rptr_q - AW'(1);
						end
					end else begin
						state_q <= S_FINAL;
					end
				end
				S_SHIFT_DN: begin
					pend_q <= rd_left_q;
					if (rd_left_q) begin
						wa_q <= rptr_q - AW'(1);
						if (last_rd) begin
							rd_left_q <= 1'b0;
						end else begin
							rptr_q <= rptr_q + AW'(1);
						end
					end else begin
						state_q <= S_FINAL;
					end
				end
				S_SEARCH: begin
					pend_q <= rd_left_q;
					if (hit) begin
						idx_q    <= wa_q;
						status_q <= ilist_pkg::ST_OK;
						state_q  <= S_DONE;
					end else if (rd_left_q) begin
						wa_q <= rptr_q;
						if (last_rd) begin
							rd_left_q <= 1'b0;
						end else begin
							rptr_q <= rptr_q + AW'(1);
						end
					end else begin
						status_q <= ilist_pkg::ST_NOTFOUND;
						state_q  <= S_DONE;
					end
				end
				S_FINAL: begin
					if (ins_q) begin
						count_q <= count_q + CW'(1);
					end else begin
						count_q <= count_q - CW'(1);
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== tb/sv/indexed_list_insert_remove_search_tb.sv =====
// Self-checking testbench for the indexed list: directed table, then phased random items.
module indexed_list_insert_remove_search_tb;

	localparam int DEPTH       = 256;
	localparam int CLK_HALF    = 5;
	localparam int CYCLE_LIMIT = 4_000_000;

	// Operation codes the block treats as no-ops.
	localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

	// One row of the directed table; want is used only where typed is set.
	typedef struct packed {
		logic [2:0]      op;
		logic [7:0]      pos;
		logic [31:0]     val;
		logic            typed;
		ilist_pkg::res_t want;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic [2:0]  operation = '0;
	logic [7:0]  position = '0;
	logic [31:0] item_value = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	logic [2:0]  status;
	logic [7:0]  found_index;
	logic [8:0]  entry_count;

	// Expectation override that travels with a directed item.
	logic            row_typed = 1'b0;
	ilist_pkg::res_t row_want = '0;

	// Shadow copy of the list and the results still owed by the block.
	logic [31:0]     list_store [DEPTH];
	int              list_len = 0;
	ilist_pkg::res_t op_results_due [$];
	plan_row_t       plan [$];

	bit idle_on = 1'b1;
	int stall_left = 0;
	int mismatches = 0;
	int cycle_count = 0;

	indexed_list_insert_remove_search #(.DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.operation(operation),
		.position(position),
		.item_value(item_value),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status(status),
		.found_index(found_index),
		.entry_count(entry_count)
	);

	always #(CLK_HALF) clk = ~clk;

	// Apply one operation to the shadow list and return the result it must give.
	function automatic ilist_pkg::res_t apply_list_op(logic [2:0] op, logic [7:0] pos,
			logic [31:0] val);
		ilist_pkg::res_t r;
		int i;
		r = '0;
		r.status = ilist_pkg::ST_OK;
		case (op)
			ilist_pkg::OP_APPEND: begin
				if (list_len >= DEPTH) begin
					r.status = ilist_pkg::ST_FULL;
				end else begin
					list_store[list_len] = val;
					list_len++;
				end
			end
			ilist_pkg::OP_INSERT: begin
				if (int'(pos) > list_len) begin
					r.status = ilist_pkg::ST_OOB;
				end else if (list_len >= DEPTH) begin
					r.status = ilist_pkg::ST_FULL;
				end else begin
					for (i = list_len; i > int'(pos); i--)
						list_store[i] = list_store[i - 1];
					list_store[pos] = val;
					list_len++;
				end
			end
			ilist_pkg::OP_REM_LAST: begin
				if (list_len == 0)
					r.status = ilist_pkg::ST_EMPTY;
				else
					list_len--;
			end
			ilist_pkg::OP_REM_AT: begin
				if (int'(pos) >= list_len) begin
					r.status = ilist_pkg::ST_OOB;
				end else begin
					for (i = int'(pos); i + 1 < list_len; i++)
						list_store[i] = list_store[i + 1];
					list_len--;
				end
			end
			ilist_pkg::OP_SEARCH: begin
				r.status = ilist_pkg::ST_NOTFOUND;
				for (i = 0; i < list_len; i++) begin
					if (list_store[i] == val) begin
						r.status = ilist_pkg::ST_OK;
						r.found_index = i[7:0];
						break;
					end
				end
			end
			default: begin
			end
		endcase
		r.entry_count = list_len[8:0];
		return r;
	endfunction

	function automatic plan_row_t plan_row(logic [2:0] op, logic [7:0] pos, logic [31:0] val,
			logic typed, logic [2:0] st, logic [7:0] idx, logic [8:0] cnt);
		plan_row_t r;
		r.op = op;
		r.pos = pos;
		r.val = val;
		r.typed = typed;
		r.want.status = st;
		r.want.found_index = idx;
		r.want.entry_count = cnt;
		return r;
	endfunction

	// Values lean on a small key set so that searches hit and duplicates occur.
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom_range(0, 5);
			4: return 32'h8000_0000;
			5: return 32'h7FFF_FFFF;
			6: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// Mostly legal indexes up to hi, with the ends favored and some wild ones.
	function automatic logic [7:0] pick_position(int hi);
		int roll;
		int top;
		roll = $urandom_range(0, 9);
		top = (hi > 255) ? 255 : hi;
		if (hi < 0 || roll < 2)
			return 8'($urandom_range(0, 255));
		if (roll == 2)
			return 8'd0;
		if (roll == 3)
			return 8'(top);
		return 8'($urandom_range(0, top));
	endfunction

	// Present one item at a falling edge and hold it until the block takes it.
	task automatic issue(logic [2:0] op, logic [7:0] pos, logic [31:0] val, logic typed,
			ilist_pkg::res_t want);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		req_valid <= 1'b1;
		operation <= op;
		position <= pos;
		item_value <= val;
		row_typed <= typed;
		row_want <= want;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
	endtask

	// Draw one random item from the given operation weights.
	task automatic random_item(int unsigned w_app, int unsigned w_ins, int unsigned w_rl,
			int unsigned w_ra, int unsigned w_find, int unsigned w_spare);
		int unsigned roll;
		logic [2:0] op;
		logic [7:0] pos;
		roll = $urandom_range(0, w_app + w_ins + w_rl + w_ra + w_find + w_spare - 1);
		if (roll < w_app)
			op = ilist_pkg::OP_APPEND;
		else if (roll < w_app + w_ins)
			op = ilist_pkg::OP_INSERT;
		else if (roll < w_app + w_ins + w_rl)
			op = ilist_pkg::OP_REM_LAST;
		else if (roll < w_app + w_ins + w_rl + w_ra)
			op = ilist_pkg::OP_REM_AT;
		else if (roll < w_app + w_ins + w_rl + w_ra + w_find)
			op = ilist_pkg::OP_SEARCH;
		else
			op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
		case (op)
			ilist_pkg::OP_INSERT: pos = pick_position(list_len);
			ilist_pkg::OP_REM_AT: pos = pick_position(list_len - 1);
			default: pos = 8'($urandom_range(0, 255));
		endcase
		issue(op, pos, pick_value(), 1'b0, '0);
	endtask

	// Hold the sender off until every owed result has come back.
	task automatic settle();
		req_valid <= 1'b0;
		do @(negedge clk); while (op_results_due.size() != 0);
	endtask

	task automatic report_mismatch(string what, ilist_pkg::res_t want, ilist_pkg::res_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%s: expected status %0d index %0d count %0d, got status %0d index %0d count %0d",
				what, want.status, want.found_index, want.entry_count,
				got.status, got.found_index, got.entry_count);
	endtask

	// Predict on every accepted item and check every accepted result.
	always @(posedge clk) begin : watch
		ilist_pkg::res_t predicted;
		ilist_pkg::res_t seen;
		ilist_pkg::res_t wanted;
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				predicted = apply_list_op(operation, position, item_value);
				if (row_typed)
					predicted = row_want;
				op_results_due.push_back(predicted);
			end
			if (rsp_valid && !rsp_stall) begin
				seen.status = status;
				seen.found_index = found_index;
				seen.entry_count = entry_count;
				if (op_results_due.size() == 0) begin
					report_mismatch("result with nothing owed", '0, seen);
				end else begin
					wanted = op_results_due.pop_front();
					if (seen.status != wanted.status || seen.found_index != wanted.found_index ||
							seen.entry_count != wanted.entry_count)
						report_mismatch("mismatch", wanted, seen);
				end
			end
		end
	end

	// Result side stalls in short random bursts while idling is enabled.
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			rsp_stall <= 1'b1;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 3);
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// Give up on a hung block.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		int n;

		// Empty list cases, spare codes, extremes, then a short mixed stretch.
		plan.push_back(plan_row(ilist_pkg::OP_REM_LAST, 8'd0, 32'd0, 1'b1,
			ilist_pkg::ST_EMPTY, 8'd0, 9'd0));
		plan.push_back(plan_row(ilist_pkg::OP_REM_AT, 8'd0, 32'd0, 1'b1,
			ilist_pkg::ST_OOB, 8'd0, 9'd0));
		plan.push_back(plan_row(ilist_pkg::OP_INSERT, 8'd1, 32'd9, 1'b1,
			ilist_pkg::ST_OOB, 8'd0, 9'd0));
		plan.push_back(plan_row(ilist_pkg::OP_SEARCH, 8'd0, 32'd0, 1'b1,
			ilist_pkg::ST_NOTFOUND, 8'd0, 9'd0));
		plan.push_back(plan_row(ilist_pkg::OP_SEARCH, 8'd255, 32'hFFFF_FFFF, 1'b1,
			ilist_pkg::ST_NOTFOUND, 8'd0, 9'd0));
		plan.push_back(plan_row(OP_SPARE_FIRST, 8'd0, 32'd0, 1'b1,
			ilist_pkg::ST_OK, 8'd0, 9'd0));
		plan.push_back(plan_row(OP_SPARE_LAST, 8'd255, 32'hFFFF_FFFF, 1'b1,
			ilist_pkg::ST_OK, 8'd0, 9'd0));
		plan.push_back(plan_row(ilist_pkg::OP_APPEND, 8'd0, 32'h8000_0000, 1'b1,
			ilist_pkg::ST_OK, 8'd0, 9'd1));
		plan.push_back(plan_row(ilist_pkg::OP_APPEND, 8'd255, 32'h7FFF_FFFF, 1'b1,
			ilist_pkg::ST_OK, 8'd0, 9'd2));
		plan.push_back(plan_row(ilist_pkg::OP_INSERT, 8'd0, 32'd0, 1'b1,
			ilist_pkg::ST_OK, 8'd0, 9'd3));
		plan.push_back(plan_row(ilist_pkg::OP_INSERT, 8'd3, 32'hFFFF_FFFF, 1'b1,
			ilist_pkg::ST_OK, 8'd0, 9'd4));
		plan.push_back(plan_row(ilist_pkg::OP_INSERT, 8'd255, 32'd1, 1'b1,
			ilist_pkg::ST_OOB, 8'd0, 9'd4));
		plan.push_back(plan_row(ilist_pkg::OP_SEARCH, 8'd0, 32'h7FFF_FFFF, 1'b0, '0, '0, '0));
		plan.push_back(plan_row(ilist_pkg::OP_SEARCH, 8'd0, 32'h8000_0000, 1'b0, '0, '0, '0));
		plan.push_back(plan_row(ilist_pkg::OP_SEARCH, 8'd0, 32'hFFFF_FFFF, 1'b0, '0, '0, '0));
		plan.push_back(plan_row(ilist_pkg::OP_APPEND, 8'd0, 32'd0, 1'b0, '0, '0, '0));
		plan.push_back(plan_row(ilist_pkg::OP_SEARCH, 8'd0, 32'd0, 1'b0, '0, '0, '0));
		plan.push_back(plan_row(ilist_pkg::OP_REM_AT, 8'd4, 32'd0, 1'b0, '0, '0, '0));
		plan.push_back(plan_row(ilist_pkg::OP_REM_AT, 8'd255, 32'd0, 1'b1,
			ilist_pkg::ST_OOB, 8'd0, 9'd4));
		plan.push_back(plan_row(ilist_pkg::OP_REM_AT, 8'd0, 32'd0, 1'b0, '0, '0, '0));
		plan.push_back(plan_row(OP_SPARE_FIRST + 3'd1, 8'd255, 32'hAAAA_5555, 1'b0,
			'0, '0, '0));
		plan.push_back(plan_row(ilist_pkg::OP_REM_LAST, 8'd0, 32'd0, 1'b0, '0, '0, '0));
		plan.push_back(plan_row(ilist_pkg::OP_SEARCH, 8'd0, 32'd0, 1'b0, '0, '0, '0));
		plan.push_back(plan_row(ilist_pkg::OP_INSERT, 8'd1, 32'h5555_AAAA, 1'b0, '0, '0, '0));

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[k])
			issue(plan[k].op, plan[k].pos, plan[k].val, plan[k].typed, plan[k].want);
		settle();

		// Grow the list to capacity, then push against the full store.
		n = 0;
		while (list_len < DEPTH && n < 800) begin
			random_item(55, 25, 3, 2, 10, 5);
			n++;
		end
		repeat (20) random_item(45, 35, 0, 0, 15, 5);
		settle();

		// Shrink it back to empty, then push against the empty store.
		n = 0;
		while (list_len > 0 && n < 1000) begin
			random_item(10, 5, 35, 35, 10, 5);
			n++;
		end
		repeat (15) random_item(0, 0, 45, 35, 15, 5);

		// Balanced traffic: a stretch without idling, one with, then another without.
		idle_on = 1'b0;
		repeat (100) random_item(20, 20, 15, 15, 25, 5);
		idle_on = 1'b1;
		repeat (250) random_item(20, 20, 15, 15, 25, 5);
		idle_on = 1'b0;
		repeat (150) random_item(20, 20, 15, 15, 25, 5);
		req_valid <= 1'b0;

		while (op_results_due.size() != 0) @(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
